// ===== sv/fatlba_pkg.sv =====
`timescale 1ns / 1ps
package fatlba_pkg;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  file_id;
    logic [30:0] length_bytes;
    logic [30:0] offset_bytes;
    logic [15:0] block_count;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [14:0] block_index;
    logic [7:0]  new_file_id;
    logic [15:0] file_blocks;
    logic [15:0] free_blocks;
  } out_t;

  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_ACCESS = 2'd1;
  localparam logic [1:0] OP_EXTEND = 2'd2;
  localparam logic [1:0] OP_SHRINK = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_SPACE  = 3'd1;
  localparam logic [2:0] ST_UNKNOWN   = 3'd2;
  localparam logic [2:0] ST_BEYOND    = 3'd3;
  localparam logic [2:0] ST_TBL_FULL  = 3'd4;

  localparam logic [1:0] CFG_BLOCK_SIZE = 2'd0;
  localparam logic [1:0] CFG_USABLE     = 2'd1;

  localparam logic [16:0] BS_RST     = 17'd1024;
  localparam logic [16:0] BS_MIN     = 17'd8;
  localparam logic [16:0] BS_MAX     = 17'd65536;
  localparam int          USABLE_RST = 32640;

endpackage

// ===== sv/fat_linked_block_allocator.sv =====
`timescale 1ns / 1ps
// A link followed passes through S_WRD and S_WWT, a used-map entry scanned through S_ARD and S_ACHK;
// a division runs bit by bit in S_DIV, then S_DIVD.
// Throughput: one transaction at a time; the next is taken once the result is registered.
// Reset (rst_n low, synchronous): clears control state, then a clearing pass over every
// block index zeroes the used map; input is stalled during it, config writes are taken.
module fat_linked_block_allocator #(
  parameter int POOL_BLOCKS = 32768,
  parameter int MAX_FILES  = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fatlba_pkg::in_t    in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output fatlba_pkg::out_t   out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_wdata
);
  import fatlba_pkg::*;

  localparam int IDXW = $clog2(POOL_BLOCKS);
  localparam int CNTW = $clog2(POOL_BLOCKS + 1);
  localparam int FIDW = $clog2(MAX_FILES);
  localparam int NFW  = $clog2(MAX_FILES + 1);
  localparam logic [CNTW-1:0] FREE_RST =
    CNTW'(POOL_BLOCKS < USABLE_RST ? POOL_BLOCKS : USABLE_RST);
  localparam logic [17:0] NUM18 = 18'(POOL_BLOCKS);
  localparam logic [IDXW-1:0] LAST_BLK = IDXW'(POOL_BLOCKS - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FRD, S_DIV, S_DIVD, S_WRD, S_WWT, S_ARD, S_ACHK, S_DONE
  } state_t;

  state_t state_r;

  logic [16:0]     bs_r;
  logic [CNTW-1:0] free_r, used_r;
  logic [NFW-1:0]  next_r;
  logic [IDXW-1:0] lo_r, clr_r;
  in_t             req_r;
  logic [FIDW-1:0] fa_r;
  logic [CNTW-1:0] size_r, keep_r, steps_r, n_r, placed_r;
  logic [IDXW-1:0] cur_r, scan_r, prev_r, first_r;
  logic            has_prev_r, freeing_r;
  logic [31:0]     dvd_r;
  logic [17:0]     rem_r;
  logic [4:0]      dcnt_r;
  logic [2:0]      res_status_r;
  logic [IDXW-1:0] res_bidx_r;
  logic [7:0]      res_nid_r;
  logic [15:0]     res_fblk_r;
  logic            out_valid_r;
  out_t            out_data_r;

  logic            used_we, used_wdata, used_rd;
  logic [IDXW-1:0] used_waddr, used_raddr;
  logic            link_we;
  logic [IDXW-1:0] link_waddr, link_wdata, link_raddr, link_rd;
  logic            fst_we, flen_we;
  logic [IDXW-1:0] fst_wdata, fst_rd;
  logic [CNTW-1:0] flen_wdata, flen_rd;

  logic [16:0] bs_eff;
  logic        walk_done, alloc_done, in_acc;
  logic [17:0] rs;
  logic        known;
  logic [CNTW-1:0] keep_w;
  logic [17:0] cap_w;

  assign bs_eff = (bs_r < BS_MIN) ? BS_MIN : ((bs_r > BS_MAX) ? BS_MAX : bs_r);
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign walk_done  = (state_r == S_WRD) && (steps_r == '0);
  assign alloc_done = (state_r == S_ARD) && (placed_r == n_r);
  assign rs    = {rem_r[16:0], dvd_r[31]};
  assign known = (32'(req_r.file_id) < 32'(next_r));
  assign keep_w = (flen_rd == '0) ? '0 :
                  ((18'(req_r.block_count) >= 18'(flen_rd)) ? CNTW'(1) :
                   CNTW'(18'(flen_rd) - 18'(req_r.block_count)));
  assign cap_w = (18'(cfg_wdata[15:0]) < NUM18) ? 18'(cfg_wdata[15:0]) : NUM18;

  always_comb begin
    used_we    = 1'b0;
    used_waddr = scan_r;
    used_wdata = 1'b0;
    used_raddr = scan_r;
    link_we    = 1'b0;
    link_waddr = prev_r;
    link_wdata = scan_r;
    link_raddr = cur_r;
    fst_we     = 1'b0;
    fst_wdata  = first_r;
    flen_we    = 1'b0;
    flen_wdata = n_r;
    case (state_r)
      S_CLEAR: begin
        used_we    = 1'b1;
        used_waddr = clr_r;
      end
      S_WWT: begin
        if (freeing_r) begin
          used_we    = 1'b1;
          used_waddr = link_rd;
        end
      end
      S_ACHK: begin
        if (!used_rd) begin
          used_we    = 1'b1;
          used_wdata = 1'b1;
          link_we    = has_prev_r;
        end
      end
      S_DIVD: begin
        if (req_r.op == OP_CREATE && dvd_r == '0) begin
          fst_we     = 1'b1;
          fst_wdata  = '0;
          flen_we    = 1'b1;
          flen_wdata = '0;
        end
      end
      S_ARD: begin
        if (alloc_done) begin
          flen_we = 1'b1;
          if (req_r.op == OP_CREATE) begin
            fst_we = 1'b1;
          end else begin
            fst_we     = (size_r == '0);
            flen_wdata = size_r + n_r;
          end
        end
      end
      S_WRD: begin
        if (walk_done && req_r.op == OP_SHRINK && freeing_r) begin
          flen_we    = 1'b1;
          flen_wdata = keep_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      bs_r        <= BS_RST;
      free_r      <= FREE_RST;
      used_r      <= '0;
      next_r      <= '0;
      lo_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == CFG_BLOCK_SIZE) bs_r <= cfg_wdata;
        else if (cfg_index == CFG_USABLE)
          free_r <= (cap_w > 18'(used_r)) ? CNTW'(cap_w - 18'(used_r)) : '0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == LAST_BLK) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            req_r   <= in_data;
            fa_r    <= FIDW'(in_data.file_id);
            state_r <= S_FRD;
          end
        end
        S_FRD: begin
          size_r       <= flen_rd;
          cur_r        <= fst_rd;
          keep_r       <= keep_w;
          freeing_r    <= 1'b0;
          res_status_r <= ST_OK;
          res_bidx_r   <= '0;
          res_nid_r    <= '0;
          res_fblk_r   <= 16'(flen_rd);
          rem_r        <= '0;
          dcnt_r       <= 5'd31;
          if (req_r.op == OP_CREATE) begin
            fa_r <= FIDW'(next_r);
            if (32'(next_r) >= MAX_FILES) begin
              res_status_r <= ST_TBL_FULL;
              res_fblk_r   <= '0;
              state_r      <= S_DONE;
            end else begin
              dvd_r   <= 32'(req_r.length_bytes) + 32'(bs_eff) - 32'd1;
              state_r <= S_DIV;
            end
          end else if (!known) begin
            res_status_r <= ST_UNKNOWN;
            res_fblk_r   <= '0;
            state_r      <= S_DONE;
          end else if (req_r.op == OP_ACCESS) begin
            dvd_r   <= 32'(req_r.offset_bytes);
            state_r <= S_DIV;
          end else if (req_r.op == OP_EXTEND) begin
            n_r        <= CNTW'(req_r.block_count);
            placed_r   <= '0;
            scan_r     <= lo_r;
            has_prev_r <= 1'b0;
            if (18'(req_r.block_count) > 18'(free_r)) begin
              res_status_r <= ST_NO_SPACE;
              state_r      <= S_DONE;
            end else if (req_r.block_count == '0) begin
              state_r <= S_DONE;
            end else if (flen_rd == '0) begin
              state_r <= S_ARD;
            end else begin
              steps_r <= flen_rd - 1'b1;
              state_r <= S_WRD;
            end
          end else begin
            res_fblk_r <= 16'(keep_w);
            if (keep_w < flen_rd) begin
              steps_r <= keep_w - 1'b1;
              state_r <= S_WRD;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_DIV: begin
          if (rs >= {1'b0, bs_eff}) begin
            rem_r <= rs - {1'b0, bs_eff};
            dvd_r <= {dvd_r[30:0], 1'b1};
          end else begin
            rem_r <= rs;
            dvd_r <= {dvd_r[30:0], 1'b0};
          end
          dcnt_r <= dcnt_r - 1'b1;
          if (dcnt_r == '0) state_r <= S_DIVD;
        end
        S_DIVD: begin
          if (req_r.op == OP_CREATE) begin
            res_fblk_r <= 16'(dvd_r);
            if (dvd_r > 32'(free_r)) begin
              res_status_r <= ST_NO_SPACE;
              state_r      <= S_DONE;
            end else if (dvd_r == '0) begin
              res_nid_r <= 8'(next_r);
              next_r    <= next_r + 1'b1;
              state_r   <= S_DONE;
            end else begin
              n_r        <= CNTW'(dvd_r);
              placed_r   <= '0;
              scan_r     <= lo_r;
              has_prev_r <= 1'b0;
              state_r    <= S_ARD;
            end
          end else begin
            if (dvd_r >= 32'(size_r)) begin
              res_status_r <= ST_BEYOND;
              state_r      <= S_DONE;
            end else begin
              steps_r <= CNTW'(dvd_r);
              state_r <= S_WRD;
            end
          end
        end
        S_WRD: begin
          if (walk_done) begin
            if (req_r.op == OP_ACCESS) begin
              res_bidx_r <= cur_r;
              state_r    <= S_DONE;
            end else if (req_r.op == OP_EXTEND) begin
              placed_r   <= '0;
              scan_r     <= lo_r;
              has_prev_r <= 1'b1;
              prev_r     <= cur_r;
              state_r    <= S_ARD;
            end else if (!freeing_r) begin
              freeing_r <= 1'b1;
              steps_r   <= size_r - keep_r;
            end else begin
              free_r  <= free_r + (size_r - keep_r);
              used_r  <= used_r - (size_r - keep_r);
              state_r <= S_DONE;
            end
          end else begin
            state_r <= S_WWT;
          end
        end
        S_WWT: begin
          cur_r   <= link_rd;
          steps_r <= steps_r - 1'b1;
          if (freeing_r && link_rd < lo_r) lo_r <= link_rd;
          state_r <= S_WRD;
        end
        S_ARD: begin
          if (alloc_done) begin
            lo_r   <= scan_r;
            free_r <= free_r - n_r;
            used_r <= used_r + n_r;
            if (req_r.op == OP_CREATE) begin
              res_bidx_r <= first_r;
              res_nid_r  <= 8'(next_r);
              next_r     <= next_r + 1'b1;
            end else begin
              res_fblk_r <= 16'(size_r + n_r);
            end
            state_r <= S_DONE;
          end else begin
            state_r <= S_ACHK;
          end
        end
        S_ACHK: begin
          if (!used_rd) begin
            if (!has_prev_r) first_r <= scan_r;
            has_prev_r <= 1'b1;
            prev_r     <= scan_r;
            placed_r   <= placed_r + 1'b1;
          end
          scan_r  <= scan_r + 1'b1;
          state_r <= S_ARD;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r              <= 1'b1;
            out_data_r.status        <= res_status_r;
            out_data_r.block_index   <= 15'(res_bidx_r);
            out_data_r.new_file_id   <= res_nid_r;
            out_data_r.file_blocks   <= res_fblk_r;
            out_data_r.free_blocks   <= 16'(free_r);
            state_r                  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  fatlba_ram #(.W(1), .D(POOL_BLOCKS)) u_used (
    .clk(clk), .we(used_we), .waddr(used_waddr), .wdata(used_wdata),
    .raddr(used_raddr), .rdata(used_rd)
  );

  fatlba_ram #(.W(IDXW), .D(POOL_BLOCKS)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_rd)
  );

  fatlba_ram #(.W(IDXW), .D(MAX_FILES)) u_fstart (
    .clk(clk), .we(fst_we), .waddr(fa_r), .wdata(fst_wdata),
    .raddr(FIDW'(in_data.file_id)), .rdata(fst_rd)
  );

  fatlba_ram #(.W(CNTW), .D(MAX_FILES)) u_flen (
    .clk(clk), .we(flen_we), .waddr(fa_r), .wdata(flen_wdata),
    .raddr(FIDW'(in_data.file_id)), .rdata(flen_rd)
  );

`ifndef NO_ASSERTIONS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    18'(used_r) <= NUM18) else $error("used count above pool size");
  a_files_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(next_r) <= MAX_FILES) else $error("file number past table");
  a_alloc_short: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACHK) |-> (placed_r < n_r)) else $error("allocation overran");
  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_valid_r) |=> out_valid_r)
    else $error("result not registered");
`endif

endmodule

// ===== sv/fatlba_ram.sv =====
`timescale 1ns / 1ps
module fatlba_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== tb/fat_linked_block_allocator_tb.sv =====
`timescale 1ns / 1ps
module fat_linked_block_allocator_tb;
  import fatlba_pkg::*;

  localparam int NBLK = 32768;
  localparam int NFILES = 256;
  localparam int STALL_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_BLOCK_SIZE;
  logic [16:0] cfg_wdata = '0;

  fat_linked_block_allocator u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // allocator mirror
  logic [15:0] chain_next[NBLK];
  bit blk_busy[NBLK];
  logic [14:0] f_first[NFILES];
  logic [15:0] f_nblk[NFILES];
  bit f_live[NFILES];
  int unsigned free_cnt;
  int unsigned next_fid;
  logic [16:0] bs_reg = BS_RST;

  out_t pending_results[$];
  int err_cnt = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;

  function automatic int unsigned eff_bs();
    if (bs_reg < BS_MIN) return 8;
    if (bs_reg > BS_MAX) return 65536;
    return bs_reg;
  endfunction

  function automatic int unsigned follow(int unsigned start, int unsigned steps);
    int unsigned cur;
    cur = start % NBLK;
    for (int unsigned k = 0; k < steps; k++) cur = chain_next[cur] % NBLK;
    return cur;
  endfunction

  // grab the n lowest free blocks, linking them after prev when has_prev
  function automatic int unsigned grab_lowest(int unsigned n, bit has_prev,
                                              int unsigned prev);
    int unsigned first, placed;
    first = 0;
    placed = 0;
    for (int i = 0; i < NBLK && placed < n; i++) begin
      if (!blk_busy[i]) begin
        blk_busy[i] = 1'b1;
        if (has_prev) chain_next[prev % NBLK] = i;
        else first = i;
        has_prev = 1'b1;
        prev = i;
        placed++;
      end
    end
    return first;
  endfunction

  function automatic out_t alloc_result(in_t t);
    out_t r;
    int unsigned bs, f, size, keep, cur, first;
    longint unsigned nb, pos;
    bit known;
    r = '0;
    bs = eff_bs();
    f = t.file_id;
    known = f_live[f];
    if (t.op == OP_CREATE) begin
      nb = (longint'(t.length_bytes) + bs - 1) / bs;
      if (next_fid >= NFILES) r.status = ST_TBL_FULL;
      else if (nb > free_cnt) begin
        r.status = ST_NO_SPACE;
        r.file_blocks = nb[15:0];
      end else begin
        first = grab_lowest(nb, 1'b0, 0);
        if (nb == 0) first = 0;
        f_first[next_fid] = first;
        f_nblk[next_fid] = nb;
        f_live[next_fid] = 1'b1;
        free_cnt -= nb;
        r.block_index = first;
        r.new_file_id = next_fid;
        r.file_blocks = nb;
        next_fid++;
      end
    end else if (!known) begin
      r.status = ST_UNKNOWN;
    end else if (t.op == OP_ACCESS) begin
      pos = t.offset_bytes / bs;
      r.file_blocks = f_nblk[f];
      if (pos >= f_nblk[f]) r.status = ST_BEYOND;
      else r.block_index = follow(f_first[f], pos);
    end else if (t.op == OP_EXTEND) begin
      size = f_nblk[f];
      r.file_blocks = size;
      if (t.block_count > free_cnt) r.status = ST_NO_SPACE;
      else if (t.block_count > 0) begin
        if (size == 0) f_first[f] = grab_lowest(t.block_count, 1'b0, 0);
        else void'(grab_lowest(t.block_count, 1'b1, follow(f_first[f], size - 1)));
        free_cnt -= t.block_count;
        f_nblk[f] = size + t.block_count;
        r.file_blocks = size + t.block_count;
      end
    end else begin
      size = f_nblk[f];
      keep = size;
      if (size > 0) keep = (t.block_count >= size) ? 1 : size - t.block_count;
      if (keep < size) begin
        cur = follow(f_first[f], keep - 1);
        for (int unsigned k = keep; k < size; k++) begin
          cur = chain_next[cur] % NBLK;
          blk_busy[cur] = 1'b0;
        end
        free_cnt += size - keep;
        f_nblk[f] = keep;
      end
      r.file_blocks = keep;
    end
    r.free_blocks = free_cnt;
    return r;
  endfunction

  // one input transaction; leaves in_valid high
  task automatic send_txn(in_t t);
    if (!no_idle && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(alloc_result(t));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [16:0] val);
    int unsigned cap, used;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_BLOCK_SIZE) bs_reg = val;
    else begin
      cap = (val[15:0] < NBLK) ? val[15:0] : NBLK;
      used = 0;
      for (int i = 0; i < NBLK; i++) used += blk_busy[i];
      free_cnt = (cap > used) ? cap - used : 0;
    end
  endtask

  function automatic in_t mk(logic [1:0] op, logic [7:0] fid, logic [30:0] len,
                             logic [30:0] off, logic [15:0] cnt);
    in_t t;
    t.op = op;
    t.file_id = fid;
    t.length_bytes = len;
    t.offset_bytes = off;
    t.block_count = cnt;
    return t;
  endfunction

  function automatic in_t random_txn();
    in_t t;
    int unsigned bs;
    longint unsigned nb;
    bs = eff_bs();
    t.op = $urandom_range(3);
    t.length_bytes = $urandom;
    t.offset_bytes = $urandom;
    t.block_count = $urandom;
    if (next_fid > 0 && $urandom_range(99) < 85) t.file_id = $urandom_range(next_fid - 1);
    else t.file_id = $urandom;
    case (t.op)
      OP_CREATE: begin
        nb = (longint'(t.length_bytes) + bs - 1) / bs;
        // huge lengths only when they are bound to fail; keeps scans short
        if ($urandom_range(99) < 90 || nb <= free_cnt)
          t.length_bytes = $urandom_range(0, 6 * bs);
      end
      OP_ACCESS:
        if ($urandom_range(99) < 80)
          t.offset_bytes = $urandom_range(0, (f_nblk[t.file_id] + 1) * bs);
      OP_EXTEND:
        if ($urandom_range(99) < 85 || t.block_count <= free_cnt)
          t.block_count = $urandom_range(0, 4);
      default:
        if ($urandom_range(99) < 80) t.block_count = $urandom_range(0, 4);
    endcase
    return t;
  endfunction

  task automatic test_directed_ops();
    send_txn(mk(OP_CREATE, 8'd0, 31'd0, '1, '1));       // empty file, id 0
    send_txn(mk(OP_CREATE, 8'd0, 31'd1, 31'd0, 16'd0)); // id 1
    send_txn(mk(OP_CREATE, 8'd0, 31'd1024, 31'd0, 16'd0));
    send_txn(mk(OP_CREATE, 8'd0, 31'd1025, 31'd0, 16'd0));
    send_txn(mk(OP_CREATE, 8'd0, 31'h7FFFFFFF, 31'd0, 16'd0));
    send_txn(mk(OP_ACCESS, 8'd3, 31'd0, 31'd1024, 16'd0));
    send_txn(mk(OP_ACCESS, 8'd3, 31'd0, 31'd2048, 16'd0));
    send_txn(mk(OP_ACCESS, 8'd0, 31'd0, 31'd0, 16'd0));
    send_txn(mk(OP_ACCESS, 8'd200, 31'd0, 31'd0, 16'd0));
    send_txn(mk(OP_EXTEND, 8'd0, 31'd0, 31'd0, 16'd0));
    send_txn(mk(OP_EXTEND, 8'd0, 31'd0, 31'd0, 16'd3));
    send_txn(mk(OP_EXTEND, 8'd1, 31'd0, 31'd0, 16'd2));
    send_txn(mk(OP_ACCESS, 8'd1, 31'd0, 31'd2047, 16'd0));
    send_txn(mk(OP_SHRINK, 8'd3, 31'd0, 31'd0, 16'd1));
    send_txn(mk(OP_SHRINK, 8'd0, 31'd0, 31'd0, 16'hFFFF));
    send_txn(mk(OP_CREATE, 8'hFF, 31'd1, 31'd0, 16'd0));
    send_txn(mk(OP_EXTEND, 8'd2, 31'd0, 31'd0, 16'd40000));
    send_txn(mk(OP_SHRINK, 8'd200, 31'd0, 31'd0, 16'd1));
    send_txn(mk(OP_EXTEND, 8'd255, 31'd0, 31'd0, 16'd1));
    send_txn(mk(OP_CREATE, 8'd0, 31'd5000, 31'd0, 16'd0));
    send_txn(mk(OP_CREATE, 8'd0, 31'd0, 31'd0, 16'd0));  // empty, id 6
    send_txn(mk(OP_SHRINK, 8'd6, 31'd0, 31'd0, 16'd2));
    send_txn(mk(OP_EXTEND, 8'd6, 31'd0, 31'd0, 16'd1));
    send_txn(mk(OP_ACCESS, 8'd1, 31'd0, 31'h7FFFFFFF, 16'd0));
    drain();
  endtask

  task automatic test_config_extremes();
    cfg_write(CFG_BLOCK_SIZE, 17'd0);     // clamps to minimum
    cfg_write(CFG_USABLE, 17'd0);
    send_txn(mk(OP_CREATE, 8'd0, 31'd0, 31'd0, 16'd0));
    send_txn(mk(OP_CREATE, 8'd0, 31'd1, 31'd0, 16'd0));
    send_txn(mk(OP_EXTEND, 8'd1, 31'd0, 31'd0, 16'd1));
    send_txn(mk(OP_ACCESS, 8'd5, 31'd0, 31'd8, 16'd0));
    drain();
    cfg_write(CFG_BLOCK_SIZE, 17'h1FFFF); // clamps to maximum
    cfg_write(CFG_USABLE, 17'hFFFF);
    send_txn(mk(OP_CREATE, 8'd0, 31'd65537, 31'd0, 16'd0));
    send_txn(mk(OP_ACCESS, 8'd8, 31'd0, 31'd65536, 16'd0));
    drain();
  endtask

  task automatic test_random_phase(logic [16:0] bs, logic [16:0] usable, int n,
                                   int calm_items, bit do_hold);
    cfg_write(CFG_BLOCK_SIZE, bs);
    cfg_write(CFG_USABLE, usable);
    for (int i = 0; i < n; i++) begin
      no_idle = (i < calm_items);
      if (do_hold && i == n / 2) hold_req = 1'b1;
      send_txn(random_txn());
    end
    no_idle = 1'b0;
    drain();
  endtask

  // receiver: random stall, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else out_stall <= !no_idle && ($urandom_range(99) < 30);
    end
  end

  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: %h", out_data);
        err_cnt++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data.status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, out_data.status); err_cnt++;
        end
        if (out_data.block_index !== exp_r.block_index) begin
          $error("block_index exp %0d got %0d", exp_r.block_index, out_data.block_index);
          err_cnt++;
        end
        if (out_data.new_file_id !== exp_r.new_file_id) begin
          $error("new_file_id exp %0d got %0d", exp_r.new_file_id, out_data.new_file_id);
          err_cnt++;
        end
        if (out_data.file_blocks !== exp_r.file_blocks) begin
          $error("file_blocks exp %0d got %0d", exp_r.file_blocks, out_data.file_blocks);
          err_cnt++;
        end
        if (out_data.free_blocks !== exp_r.free_blocks) begin
          $error("free_blocks exp %0d got %0d", exp_r.free_blocks, out_data.free_blocks);
          err_cnt++;
        end
      end
    end
  end

  // watchdog: cycles with no transaction on either channel
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NBLK; i++) begin
      blk_busy[i] = 1'b0;
      chain_next[i] = '0;
    end
    for (int i = 0; i < NFILES; i++) begin
      f_live[i] = 1'b0;
      f_nblk[i] = '0;
      f_first[i] = '0;
    end
    free_cnt = USABLE_RST;
    next_fid = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_ops();
    test_config_extremes();
    test_random_phase(17'd16, 17'd400, 520, 0, 1'b1);
    test_random_phase(BS_MAX, 17'd32768, 500, 200, 1'b0);
    test_random_phase(17'd1000, 17'd300, 530, 0, 1'b0);
    if (err_cnt == 0 && pending_results.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
